// File: rtl/qbsg_pkg.sv
// Shared types, constants and the sine table function of the queued beep tone generator.
// Used by every module in rtl/; depends on nothing else.
package qbsg_pkg;

    // Item kinds carried on the slave-side tuser.
    typedef enum logic
    {
        KIND_ENQUEUE = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    // Reset value of the amplitude register.
    localparam logic [14:0] AMPLITUDE_RESET = 15'd28000;

    // Q30 unit and the odd polynomial coefficients of sin(t * pi / 2).
    localparam longint Q30 = 64'sd1073741824;
    localparam longint C1  = 64'sd1686629713;
    localparam longint C3  = -64'sd693598668;
    localparam longint C5  = 64'sd85569306;
    localparam longint C7  = -64'sd5026995;
    localparam longint C9  = 64'sd172272;

    // A beep request after conversion: phase step and sample count.
    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] step;
        logic [31:0] count;
    } beep_item_t;

    // Word from the queue stage to the output stage.
    typedef struct packed
    {
        logic [16:0] magnitude;
        logic        negate;
        logic        is_tick;
        logic        dropped;
        logic [3:0]  level;
    } tone_word_t;

    // One quarter-wave table entry in Q16, evaluated at elaboration only.
    function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned bits);
        longint t;
        longint t2;
        longint a;
        longint y;
        t  = longint'(k) * (Q30 >>> bits);
        t2 = (t * t) / Q30;
        a  = C9;
        a  = C7 + (a * t2) / Q30;
        a  = C5 + (a * t2) / Q30;
        a  = C3 + (a * t2) / Q30;
        a  = C1 + (a * t2) / Q30;
        y  = (a * t) / Q30;
        if (y < 0)
        begin
            y = 0;
        end
        if (y > Q30)
        begin
            y = Q30;
        end
        return 17'((y + 64'sd8192) >>> 14);
    endfunction

endpackage

// File: rtl/qbsg_beep_calc.sv
// Conversion pipeline: turns frequency and duration into phase step and sample count.
// Five register stages; division by constants is done by reciprocal multiplication.
// Depends on qbsg_pkg.
module qbsg_beep_calc #(
    parameter int SAMPLE_RATE = 48000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qbsg_pkg::kind_t      in_kind,
    input  logic [18:0]          in_freq,
    input  logic [15:0]          in_dur,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qbsg_pkg::beep_item_t out_item
);
    import qbsg_pkg::*;

    // Step: freq * 2^28 / SR = freq * STEP_Q + (freq * STEP_R) / SR.
    localparam logic [15:0] STEP_Q = 16'((64'd1 << 28) / SAMPLE_RATE);
    localparam logic [17:0] STEP_R = 18'((64'd1 << 28) % SAMPLE_RATE);
    localparam int          STEP_K = $clog2(SAMPLE_RATE + 1) - 1;
    localparam logic [19:0] STEP_M = 20'((64'd1 << (STEP_K + 20)) / SAMPLE_RATE);
    localparam logic [17:0] SR_W   = 18'(SAMPLE_RATE);
    // Count: dur * SR / 1000 = dur * CNT_A + (dur * CNT_B) / 1000.
    localparam logic [7:0]  CNT_A  = 8'(SAMPLE_RATE / 1000);
    localparam logic [9:0]  CNT_B  = 10'(SAMPLE_RATE % 1000);
    localparam logic [16:0] CNT_M  = 17'((64'd1 << 26) / 1000);
    localparam logic [9:0]  MS_W   = 10'd1000;

    typedef struct packed
    {
        kind_t       kind;
        logic [18:0] freq;
        logic [15:0] dur;
    } st1_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] step_base;
        logic [36:0] x;
        logic [23:0] count_base;
        logic [25:0] y;
    } st2_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] step_base;
        logic [36:0] x;
        logic [23:0] count_base;
        logic [25:0] y;
        logic [18:0] qx;
        logic [15:0] qy;
    } st3_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [31:0] step_base;
        logic [36:0] x;
        logic [23:0] count_base;
        logic [25:0] y;
        logic [18:0] qx;
        logic [15:0] qy;
        logic [36:0] px;
        logic [25:0] py;
    } st4_t;

    st1_t       st1_reg;
    st2_t       st2_reg;
    st2_t       st2_next;
    st3_t       st3_reg;
    st3_t       st3_next;
    st4_t       st4_reg;
    st4_t       st4_next;
    beep_item_t st5_reg;
    beep_item_t st5_next;
    logic [4:0] valid_reg;
    logic [4:0] ready;

    logic [19:0] xh;
    logic [39:0] qx_prod;
    logic [16:0] yh;
    logic [33:0] qy_prod;
    logic [36:0] rx;
    logic [25:0] ry;
    logic [18:0] qx_fix;
    logic [15:0] qy_fix;

    // Each stage loads when it is empty or its successor moves on.
    assign ready[4] = !valid_reg[4] || out_ready;
    assign ready[3] = !valid_reg[3] || ready[4];
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];
    assign in_ready  = ready[0];
    assign out_valid = valid_reg[4];
    assign out_item  = st5_reg;

    // Stage 1 to 2: the four small products of the base terms.
    always_comb
    begin
        st2_next.kind       = st1_reg.kind;
        st2_next.step_base  = 32'(35'(st1_reg.freq) * 35'(STEP_Q));
        st2_next.x          = 37'(st1_reg.freq) * 37'(STEP_R);
        st2_next.count_base = 24'(st1_reg.dur) * 24'(CNT_A);
        st2_next.y          = 26'(st1_reg.dur) * 26'(CNT_B);
    end

    // Stage 2 to 3: quotient estimates, low by at most two.
    always_comb
    begin
        xh      = 20'(st2_reg.x >> STEP_K);
        qx_prod = 40'(xh) * 40'(STEP_M);
        yh      = st2_reg.y[25:9];
        qy_prod = 34'(yh) * 34'(CNT_M);
        st3_next.kind       = st2_reg.kind;
        st3_next.step_base  = st2_reg.step_base;
        st3_next.x          = st2_reg.x;
        st3_next.count_base = st2_reg.count_base;
        st3_next.y          = st2_reg.y;
        st3_next.qx         = qx_prod[38:20];
        st3_next.qy         = qy_prod[32:17];
    end

    // Stage 3 to 4: multiply the estimates back by the divisors.
    always_comb
    begin
        st4_next.kind       = st3_reg.kind;
        st4_next.step_base  = st3_reg.step_base;
        st4_next.x          = st3_reg.x;
        st4_next.count_base = st3_reg.count_base;
        st4_next.y          = st3_reg.y;
        st4_next.qx         = st3_reg.qx;
        st4_next.qy         = st3_reg.qy;
        st4_next.px         = 37'(st3_reg.qx) * 37'(SR_W);
        st4_next.py         = 26'(st3_reg.qy) * 26'(MS_W);
    end

    // Stage 4 to 5: correct the quotients from the remainders and add the base terms.
    always_comb
    begin
        rx = st4_reg.x - st4_reg.px;
        ry = st4_reg.y - st4_reg.py;
        qx_fix = st4_reg.qx;
        if (rx >= 37'(2 * SAMPLE_RATE))
        begin
            qx_fix = st4_reg.qx + 19'd2;
        end
        else if (rx >= 37'(SAMPLE_RATE))
        begin
            qx_fix = st4_reg.qx + 19'd1;
        end
        qy_fix = st4_reg.qy;
        if (ry >= 26'd2000)
        begin
            qy_fix = st4_reg.qy + 16'd2;
        end
        else if (ry >= 26'd1000)
        begin
            qy_fix = st4_reg.qy + 16'd1;
        end
        st5_next.kind  = st4_reg.kind;
        st5_next.step  = st4_reg.step_base + 32'(qx_fix);
        st5_next.count = 32'(st4_reg.count_base + 24'(qy_fix));
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (ready[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (ready[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (ready[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
            if (ready[4])
            begin
                valid_reg[4] <= valid_reg[3];
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            st1_reg.kind <= in_kind;
            st1_reg.freq <= in_freq;
            st1_reg.dur  <= in_dur;
        end
        if (ready[1])
        begin
            st2_reg <= st2_next;
        end
        if (ready[2])
        begin
            st3_reg <= st3_next;
        end
        if (ready[3])
        begin
            st4_reg <= st4_next;
        end
        if (ready[4])
        begin
            st5_reg <= st5_next;
        end
    end

endmodule

// File: rtl/qbsg_tone_queue.sv
// Beep queue, phase accumulator and quarter-wave sine lookup.
// Takes converted beep items and ticks in order; depends on qbsg_pkg.
module qbsg_tone_queue #(
    parameter int QUEUE_DEPTH     = 8,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qbsg_pkg::beep_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qbsg_pkg::tone_word_t out_word
);
    import qbsg_pkg::*;

    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TBL_SIZE = 1 << SINE_TABLE_BITS;
    localparam int IDX_W    = SINE_TABLE_BITS + 1;

    logic [31:0]      step_store [QUEUE_DEPTH];
    logic [31:0]      left_store [QUEUE_DEPTH];
    logic [16:0]      sine_rom   [TBL_SIZE + 1];

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      phase_reg;
    logic [31:0]      phase_next;
    logic             valid_reg;
    tone_word_t       word_reg;
    tone_word_t       word_next;

    logic                       fire;
    logic                       full;
    logic                       enq_write;
    logic                       tick_take;
    logic [31:0]                head_left;
    logic [SINE_TABLE_BITS-1:0] tbl_pos;
    logic [IDX_W-1:0]           tbl_idx;

    // Quarter-wave table, constant after elaboration.
    for (genvar k = 0; k <= TBL_SIZE; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    assign fire      = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_left = left_store[head_reg];

    // Table index: mirrored in the odd quadrants.
    assign tbl_pos = phase_reg[29 -: SINE_TABLE_BITS];
    assign tbl_idx = phase_reg[30] ? (IDX_W'(TBL_SIZE) - IDX_W'(tbl_pos)) : IDX_W'(tbl_pos);

    // Queue and phase update for the word being taken.
    always_comb
    begin
        enq_write  = fire && (in_item.kind == KIND_ENQUEUE) && (in_item.count != 32'd0) && !full;
        tick_take  = fire && (in_item.kind == KIND_TICK) && (count_reg != '0);
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        if (enq_write)
        begin
            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (tick_take)
        begin
            phase_next = phase_reg + step_store[head_reg];
            if (head_left == 32'd1)
            begin
                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next = count_reg - 1'b1;
            end
        end
        word_next.magnitude = tick_take ? sine_rom[tbl_idx] : '0;
        word_next.negate    = phase_reg[31];
        word_next.is_tick   = (in_item.kind == KIND_TICK);
        word_next.dropped   = (in_item.kind == KIND_ENQUEUE) && (in_item.count != 32'd0) && full;
        word_next.level     = 4'(count_next);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    // Beep stores and the result word.
    always_ff @(posedge clk)
    begin
        if (enq_write)
        begin
            step_store[tail_reg] <= in_item.step;
            left_store[tail_reg] <= in_item.count;
        end
        else if (tick_take)
        begin
            left_store[head_reg] <= head_left - 32'd1;
        end
        if (in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: rtl/qbsg_sample_out.sv
// Output stage: scales the table value by the amplitude register and holds the result word.
// Also holds the amplitude register and its write channel; depends on qbsg_pkg.
module qbsg_sample_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [14:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qbsg_pkg::tone_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   sample,
    output logic                 sample_valid,
    output logic                 request_dropped,
    output logic [3:0]           queue_level
);
    import qbsg_pkg::*;

    logic [14:0] amp_reg;
    logic        valid_reg;
    logic [15:0] sample_reg;
    logic [15:0] sample_next;
    logic        tick_reg;
    logic        dropped_reg;
    logic [3:0]  level_reg;
    logic [31:0] product;

    assign cfg_ready       = 1'b1;
    assign in_ready        = !valid_reg || out_ready;
    assign out_valid       = valid_reg;
    assign sample          = sample_reg;
    assign sample_valid    = tick_reg;
    assign request_dropped = dropped_reg;
    assign queue_level     = level_reg;

    // Scale, truncate, then apply the sign of the lower half-turn.
    always_comb
    begin
        product     = 32'(amp_reg) * 32'(in_word.magnitude);
        sample_next = in_word.negate ? (16'd0 - product[31:16]) : product[31:16];
    end

    // Amplitude register and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg   <= AMPLITUDE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                amp_reg <= cfg_data;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            sample_reg  <= sample_next;
            tick_reg    <= in_word.is_tick;
            dropped_reg <= in_word.dropped;
            level_reg   <= in_word.level;
        end
    end

endmodule

// File: rtl/queued_beep_sine_generator.sv
// Top level of the queued beep tone generator: stream ports and module wiring.
// Depends on qbsg_pkg, qbsg_beep_calc, qbsg_tone_queue and qbsg_sample_out.
//
// Every input word gives exactly one result word. An enqueue word (tuser 0) converts
// its frequency and millisecond duration into a phase step and a sample count and
// queues the beep, or flags it as dropped when the queue is full; zero-length beeps
// are ignored. A tick word (tuser 1) produces one sample of the front beep and moves
// the phase on, or 0 with the phase held when the queue is empty. The block takes one
// word per clock cycle while results are taken; each word passes through the
// five-stage conversion pipeline, the queue stage and the amplitude multiply in
// the output register. Backpressure collapses bubbles stage by stage. The amplitude
// register may be written at any time through the cfg channel, which is always ready,
// but should be changed only while no words are in flight.
module queued_beep_sine_generator #(
    parameter int QUEUE_DEPTH     = 8,
    parameter int SAMPLE_RATE     = 48000,
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,   // amplitude
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [18:0] tone_freq, [34:19] duration_ms, zero fill
    input  logic [0:0]  s_tuser,    // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [15:0] sample, [16] request_dropped, [20:17] queue_level
    output logic [0:0]  m_tuser     // [0] sample_valid
);
    import qbsg_pkg::*;

    logic               calc_valid;
    logic               calc_ready;
    beep_item_t         calc_item;
    logic               tone_valid;
    logic               tone_ready;
    tone_word_t         tone_word;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               request_dropped;
    logic [3:0]         queue_level;

    // Step and count conversion.
    qbsg_beep_calc #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (kind_t'(s_tuser[0])),
        .in_freq   (s_tdata[18:0]),
        .in_dur    (s_tdata[34:19]),
        .out_valid (calc_valid),
        .out_ready (calc_ready),
        .out_item  (calc_item)
    );

    // Beep queue and oscillator.
    qbsg_tone_queue #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (calc_valid),
        .in_ready  (calc_ready),
        .in_item   (calc_item),
        .out_valid (tone_valid),
        .out_ready (tone_ready),
        .out_word  (tone_word)
    );

    // Amplitude scaling and result register.
    qbsg_sample_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (tone_valid),
        .in_ready        (tone_ready),
        .in_word         (tone_word),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .sample          (sample),
        .sample_valid    (sample_valid),
        .request_dropped (request_dropped),
        .queue_level     (queue_level)
    );

    // Pack the result word.
    assign m_tdata = {3'b000, queue_level, request_dropped, sample};
    assign m_tuser = sample_valid;

endmodule

// File: tb/queued_beep_sine_generator_checker.sv
// Checker for the queued beep tone generator: watches the cfg, input and result channels,
// predicts every result word and compares it field by field. Depends on qbsg_pkg.
// Hands its mismatch count, the number of results still due and the predicted queue level out.
module queued_beep_sine_generator_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [14:0] cfg_data,   // amplitude
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // [18:0] tone_freq, [34:19] duration_ms, zero fill
    input  logic [0:0]  s_tuser,    // [0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [15:0] sample, [16] request_dropped, [20:17] queue_level
    input  logic [0:0]  m_tuser,    // [0] sample_valid
    output int          fail_count,
    output int          pending,
    output logic [3:0]  beep_level
);
    import qbsg_pkg::*;

    localparam int     BEEP_SLOTS   = 8;
    localparam longint RATE_HZ      = 48000;
    localparam int     LUT_BITS     = 8;
    localparam int     REPORT_LIMIT = 10;

    // Q30 unit and the odd polynomial terms of sin(t * pi / 2).
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint K1      = 64'sd1686629713;
    localparam longint K3      = -64'sd693598668;
    localparam longint K5      = 64'sd85569306;
    localparam longint K7      = -64'sd5026995;
    localparam longint K9      = 64'sd172272;

    typedef struct packed
    {
        logic [15:0] pcm;
        logic        tick;
        logic        dropped;
        logic [3:0]  level;
    } tone_result_t;

    logic [16:0]  quarter_wave [0:(1 << LUT_BITS)];
    logic [31:0]  step_slot [BEEP_SLOTS];
    logic [31:0]  left_slot [BEEP_SLOTS];
    int unsigned  head_idx;
    int unsigned  tail_idx;
    int unsigned  held;
    logic [31:0]  phase;
    logic [14:0]  amp;
    tone_result_t due_tones [$];
    int           fails;
    int unsigned  results_seen;

    // One quarter-wave point in Q16, from a fixed-point odd polynomial.
    function automatic logic [16:0] quarter_wave_point(input int unsigned k);
        longint ang;
        longint ang_sq;
        longint acc;
        longint y;
        ang    = longint'(k) * (ONE_Q30 / longint'(1 << LUT_BITS));
        ang_sq = (ang * ang) / ONE_Q30;
        acc    = K9;
        acc    = K7 + (acc * ang_sq) / ONE_Q30;
        acc    = K5 + (acc * ang_sq) / ONE_Q30;
        acc    = K3 + (acc * ang_sq) / ONE_Q30;
        acc    = K1 + (acc * ang_sq) / ONE_Q30;
        y      = (acc * ang) / ONE_Q30;
        if (y < 0)
        begin
            y = 0;
        end
        if (y > ONE_Q30)
        begin
            y = ONE_Q30;
        end
        return 17'((y + 64'sd8192) >>> 14);
    endfunction

    // Scaled sine of a phase: mirror the index in odd quadrants, negate in the lower half.
    function automatic logic [15:0] tone_level(input logic [31:0] ph, input logic [14:0] a);
        logic [8:0]  idx;
        logic [47:0] prod;
        logic [15:0] mag;
        idx = {1'b0, ph[29 -: LUT_BITS]};
        if (ph[30])
        begin
            idx = 9'(1 << LUT_BITS) - idx;
        end
        prod = 48'(a) * 48'(quarter_wave[idx]);
        mag  = prod[31:16];
        if (ph[31])
        begin
            mag = -mag;
        end
        return mag;
    endfunction

    initial
    begin
        for (int k = 0; k <= (1 << LUT_BITS); k++)
        begin
            quarter_wave[k] = quarter_wave_point(k);
        end
    end

    // Prediction and comparison, all on the words accepted at this edge.
    always @(posedge clk)
    begin
        tone_result_t want;
        tone_result_t got;
        logic [18:0]  freq;
        logic [15:0]  dur;
        logic [63:0]  wide;
        logic [31:0]  step;
        logic [31:0]  count;
        if (!rst_n)
        begin
            head_idx = 0;
            tail_idx = 0;
            held     = 0;
            phase    = '0;
            amp      = AMPLITUDE_RESET;
            fails    = 0;
            results_seen = 0;
            due_tones.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                amp = cfg_data;
            end

            // A result word is checked against the oldest word still due.
            if (m_tvalid && m_tready)
            begin
                got = '{pcm: m_tdata[15:0], tick: m_tuser[0], dropped: m_tdata[16],
                        level: m_tdata[20:17]};
                results_seen++;
                if (due_tones.size() == 0)
                begin
                    if (fails < REPORT_LIMIT)
                    begin
                        $display("Result word %0d arrived with nothing due: pcm %0d tick %0b",
                                 results_seen, $signed(got.pcm), got.tick);
                    end
                    fails++;
                end
                else
                begin
                    want = due_tones.pop_front();
                    if (got != want)
                    begin
                        if (fails < REPORT_LIMIT)
                        begin
                            $display("Mismatch on result word %0d:", results_seen);
                            $display("  expected pcm %0d tick %0b dropped %0b level %0d",
                                     $signed(want.pcm), want.tick, want.dropped, want.level);
                            $display("  got      pcm %0d tick %0b dropped %0b level %0d",
                                     $signed(got.pcm), got.tick, got.dropped, got.level);
                        end
                        fails++;
                    end
                end
            end

            // An input word updates the queue and phase and leaves one result due.
            if (s_tvalid && s_tready)
            begin
                want = '0;
                freq = s_tdata[18:0];
                dur  = s_tdata[34:19];
                if (kind_t'(s_tuser[0]) == KIND_ENQUEUE)
                begin
                    count = 32'((64'(dur) * 64'(RATE_HZ)) / 64'd1000);
                    wide  = (64'(freq) << 28) / 64'(RATE_HZ);
                    step  = wide[31:0];
                    // A beep of zero length is thrown away without a flag.
                    if (count != 0)
                    begin
                        if (held >= BEEP_SLOTS)
                        begin
                            want.dropped = 1'b1;
                        end
                        else
                        begin
                            step_slot[tail_idx] = step;
                            left_slot[tail_idx] = count;
                            tail_idx = (tail_idx + 1) % BEEP_SLOTS;
                            held++;
                        end
                    end
                end
                else
                begin
                    want.tick = 1'b1;
                    if (held != 0)
                    begin
                        want.pcm = tone_level(phase, amp);
                        phase = phase + step_slot[head_idx];
                        left_slot[head_idx] = left_slot[head_idx] - 32'd1;
                        if (left_slot[head_idx] == 0)
                        begin
                            head_idx = (head_idx + 1) % BEEP_SLOTS;
                            held--;
                        end
                    end
                end
                want.level = 4'(held);
                due_tones.push_back(want);
            end
        end
        fail_count <= fails;
        pending    <= due_tones.size();
        beep_level <= 4'(held);
    end

endmodule

// File: tb/queued_beep_sine_generator_test.sv
// Top of the queued beep tone generator testbench: clock, reset, stimulus and verdict.
// Depends on qbsg_pkg, the block under test and queued_beep_sine_generator_checker.
module queued_beep_sine_generator_test;
    import qbsg_pkg::*;

    localparam int QUEUE_SLOTS    = 8;
    localparam int ITEM_TARGET    = 1500;
    localparam int CFG_SPACING    = 250;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int          fail_count;
    int          pending;
    logic [3:0]  beep_level;

    int          tx_gap        = 1;
    bit          calm          = 1'b0;
    bit          sink_calm     = 1'b0;
    bit          last_was_beep = 1'b0;
    int unsigned n_sent        = 0;
    int unsigned n_beeps       = 0;
    int unsigned n_ticks       = 0;
    int unsigned n_zero        = 0;
    int unsigned n_full        = 0;
    int unsigned n_cfg         = 0;
    int unsigned quiet_cycles  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    queued_beep_sine_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    queued_beep_sine_generator_checker scoreboard
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .beep_level (beep_level)
    );

    // Mostly full-range frequencies, some low ones.
    function automatic logic [18:0] pick_freq();
        if ($urandom_range(0, 3) == 0)
        begin
            return 19'($urandom_range(0, 4095));
        end
        return 19'($urandom_range(0, 524287));
    endfunction

    // Present one word, wait for it to be taken, then draw the gap before the next one.
    task automatic send_word(input kind_t kind, input logic [18:0] freq, input logic [15:0] dur);
        if (tx_gap > 0)
        begin
            repeat (tx_gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, dur, freq};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        tx_gap = calm ? 0 : $urandom_range(0, 8);
        if (tx_gap > 0)
        begin
            s_tvalid <= 1'b0;
        end
        last_was_beep = (kind == KIND_ENQUEUE);
        if (kind == KIND_TICK)
        begin
            n_ticks++;
            n_sent++;
        end
        else if (dur == 16'd0)
        begin
            n_zero++;
        end
        else
        begin
            n_beeps++;
            n_sent++;
        end
    endtask

    // Tick words carry random bits in the unused fields.
    task automatic send_tick();
        send_word(KIND_TICK, 19'($urandom_range(0, 524287)), 16'($urandom_range(0, 65535)));
    endtask

    // Lower valid if it is still up, so the sender is quiet until the next word.
    task automatic stop_sender();
        if (tx_gap == 0)
        begin
            s_tvalid <= 1'b0;
        end
        tx_gap = 1;
    endtask

    // The amplitude changes only with the block drained of words.
    task automatic write_amplitude(input logic [14:0] value);
        stop_sender();
        // One edge first, so the count of due results includes the last word sent.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // Result side: a random stall before each word, with calm stretches now and then.
    initial
    begin
        int stall;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            if ($urandom_range(0, 39) == 0)
            begin
                sink_calm = !sink_calm;
            end
        end
    end

    // The run ends if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus: a directed opening, then random bursts of beeps and runs of ticks.
    initial
    begin
        int unsigned next_cfg_at;
        int unsigned cfg_round;
        int unsigned burst_len;
        int unsigned tick_len;
        logic [14:0] amp_value;
        next_cfg_at = CFG_SPACING;
        cfg_round   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Silence on an empty queue, a zero-length beep, the frequency extremes.
        send_tick();
        send_word(KIND_ENQUEUE, 19'($urandom_range(0, 524287)), 16'd0);
        send_word(KIND_ENQUEUE, 19'h7FFFF, 16'd1);
        send_word(KIND_ENQUEUE, 19'd0, 16'd1);
        repeat (QUEUE_SLOTS - 2) send_word(KIND_ENQUEUE, pick_freq(), 16'($urandom_range(1, 2)));
        // The queue is now full: the longest beep is dropped, a zero-length one is not flagged.
        send_word(KIND_ENQUEUE, 19'h7FFFF, 16'hFFFF);
        n_full++;
        send_word(KIND_ENQUEUE, pick_freq(), 16'd0);
        repeat (8) send_tick();

        while (n_sent < ITEM_TARGET)
        begin
            if (n_sent >= next_cfg_at)
            begin
                case (cfg_round)
                    0:       amp_value = 15'h7FFF;
                    1:       amp_value = 15'd0;
                    2:       amp_value = 15'd1;
                    default: amp_value = 15'($urandom_range(0, 32767));
                endcase
                write_amplitude(amp_value);
                cfg_round++;
                next_cfg_at += CFG_SPACING;
            end
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) <= 5)
            begin
                // Short beeps, so the queue both fills and drains within the run.
                burst_len = $urandom_range(1, 10);
                repeat (burst_len)
                begin
                    if (beep_level == 4'(QUEUE_SLOTS) && last_was_beep)
                    begin
                        // Any length at all may go at a full queue: a nonzero one is dropped, a zero one ignored.
                        send_word(KIND_ENQUEUE, pick_freq(), 16'($urandom_range(0, 65535)));
                        n_full++;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        send_word(KIND_ENQUEUE, pick_freq(), 16'd0);
                    end
                    else
                    begin
                        send_word(KIND_ENQUEUE, pick_freq(), 16'($urandom_range(1, 2)));
                    end
                end
                tick_len = $urandom_range(20, 150);
            end
            else
            begin
                tick_len = $urandom_range(40, 300);
            end
            repeat (tick_len) send_tick();
        end

        stop_sender();
        // One edge first, so the count of due results includes the last word sent.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d beep requests (%0d at a full queue, %0d of zero length), %0d ticks,",
                 n_beeps, n_full, n_zero, n_ticks);
        $display("%0d amplitude writes and %0d mismatching result words.", n_cfg, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/qbsg_pkg.sv
rtl/qbsg_beep_calc.sv
rtl/qbsg_tone_queue.sv
rtl/qbsg_sample_out.sv
rtl/queued_beep_sine_generator.sv
tb/queued_beep_sine_generator_checker.sv
tb/queued_beep_sine_generator_test.sv
